/* design/lifo_stack_with_search_remove_assert.svh */
// ----------------------------------------------------------------------------
// lifo stack assertion macros
// shared property forms for the checker of the lifo stack
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_SEARCH_REMOVE_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_REMOVE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LSS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define LSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/lss_pkg.sv */
// ----------------------------------------------------------------------------
// lifo stack package
// operation, status and cell command codes shared by the stack files
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

   localparam int OPERATION_WIDTH = 3;
   localparam int OPERAND_WIDTH   = 32;
   localparam int RESULT_WIDTH    = 32;
   localparam int DISTANCE_WIDTH  = 4;
   localparam int STATUS_WIDTH    = 2;
   localparam int OCCUPANCY_WIDTH = 5;

   typedef enum logic [OPERATION_WIDTH-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_SEARCH = 3'd3,
      OP_REMOVE = 3'd4
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   // what every cell does with its word
   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_PUSH   = 2'd1,
      CMD_POP    = 2'd2,
      CMD_REMOVE = 2'd3
   } cell_cmd_type;

endpackage

`default_nettype wire

/* design/lss_if.sv */
// ----------------------------------------------------------------------------
// lifo stack channels
// valid/ready interfaces for the request and response channels
// ----------------------------------------------------------------------------
`default_nettype none

interface lss_req_if;
   import lss_pkg::*;
   logic                               valid;
   logic                               ready;
   logic [OPERATION_WIDTH-1:0]         operation;
   logic signed [OPERAND_WIDTH-1:0]    operand_value;

   modport source (output valid, output operation, output operand_value, input ready);
   modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

interface lss_rsp_if;
   import lss_pkg::*;
   logic                               valid;
   logic                               ready;
   logic signed [RESULT_WIDTH-1:0]     result_value;
   logic                               found;
   logic [DISTANCE_WIDTH-1:0]          distance_from_top;
   logic [STATUS_WIDTH-1:0]            status;
   logic [OCCUPANCY_WIDTH-1:0]         occupancy;

   modport source (output valid, output result_value, output found,
                   output distance_from_top, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input result_value, input found,
                   input distance_from_top, input status, input occupancy,
                   output ready);
endinterface

`default_nettype wire

/* design/lifo_stack_with_search_remove.sv */
// ----------------------------------------------------------------------------
// lifo stack with search and remove
// fixed-depth stack of signed words built as a row of shifting cells
// ----------------------------------------------------------------------------
// usage:
//   req_if carries one operation per transfer: push, pop, peek, search or
//   remove, with the operand value. rsp_if returns exactly one result per
//   request: popped or top value, found flag, distance of the topmost match
//   below the top, status (ok, underflow, overflow) and occupancy after it.
//   the top of stack sits in cell 0; push shifts every cell down, pop shifts
//   every cell up, remove shifts up only the cells at and below the topmost
//   match. every cell compares its word with the operand in parallel and a
//   hit flag ripples down the row. the result is registered and valid in
//   the cycle after the request transfer. the stack takes one request per
//   cycle while the receiver takes each response; the response register
//   frees up in the same cycle it is taken, so back-to-back transfers
//   keep flowing.
//   reset (synchronous, active high) empties the stack and drops any pending
//   response; stored words are not cleared.
//   when the receiver stalls, the response holds and req_if.ready falls,
//   so no request is taken until the result is delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_with_search_remove #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lss_req_if.sink    req_if,
   lss_rsp_if.source  rsp_if
);
   import lss_pkg::*;

   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam int IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // cell row
   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]       cell_match;
   logic [DEPTH:0]         hit_chain;
   cell_cmd_type           cell_cmd;
   logic [VALUE_WIDTH-1:0] key;

   // control
   logic [CntWidth-1:0]    count_ff, count_in;
   logic                   req_accept;
   logic                   stack_full, stack_empty, found_any;
   logic [IdxWidth-1:0]    match_idx;
   cell_cmd_type           op_cmd;

   // response register
   logic                   rsp_valid_ff;
   logic [RESULT_WIDTH-1:0]    result_ff, result_in;
   logic                       found_ff, found_in;
   logic [DISTANCE_WIDTH-1:0]  dist_ff, dist_in;
   status_type                 status_ff, status_in;
   logic [OCCUPANCY_WIDTH-1:0] occ_ff, occ_in;

   // width helpers
   logic [63:0]                         operand_ext;
   logic [VALUE_WIDTH+63:0]             top_ext;
   logic [IdxWidth+DISTANCE_WIDTH-1:0]  dist_wide;
   logic [CntWidth+OCCUPANCY_WIDTH-1:0] occ_wide;

   // operand sign-extended then cut to the stored width
   assign operand_ext = {{32{req_if.operand_value[OPERAND_WIDTH-1]}}, req_if.operand_value};
   assign key         = operand_ext[VALUE_WIDTH-1:0];
   assign top_ext     = {{64{cell_value[0][VALUE_WIDTH-1]}}, cell_value[0]};

   assign req_accept  = req_if.valid && req_if.ready;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;

   assign stack_full  = (count_ff == CntWidth'(DEPTH));
   assign stack_empty = (count_ff == '0);
   assign hit_chain[0] = 1'b0;
   assign found_any   = hit_chain[DEPTH];

   // cells only change on an accepted request
   assign cell_cmd = req_accept ? op_cmd : CMD_HOLD;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [VALUE_WIDTH-1:0] upper_value, lower_value;
      logic                   occupied;

      assign occupied = (CntWidth'(g) < count_ff);

      if (g == 0) begin : g_top
         assign upper_value = key;
      end else begin : g_mid
         assign upper_value = cell_value[g-1];
      end

      // the bottom cell keeps its own word on a shift up; it is then unused
      if (g == DEPTH - 1) begin : g_bottom
         assign lower_value = cell_value[g];
      end else begin : g_above
         assign lower_value = cell_value[g+1];
      end

      lss_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .key         (key),
         .occupied    (occupied),
         .upper_value (upper_value),
         .lower_value (lower_value),
         .hit_in      (hit_chain[g]),
         .hit_out     (hit_chain[g+1]),
         .match       (cell_match[g]),
         .value       (cell_value[g])
      );
   end

   // topmost match: cell index equals distance from the top
   always_comb begin
      match_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            match_idx = IdxWidth'(i);
         end
      end
   end

   assign dist_wide = {{DISTANCE_WIDTH{1'b0}}, match_idx};

   // operation decode
   always_comb begin
      op_cmd    = CMD_HOLD;
      count_in  = count_ff;
      result_in = '0;
      found_in  = 1'b0;
      dist_in   = '0;
      status_in = ST_OK;
      case (op_type'(req_if.operation))
         OP_PUSH: begin
            if (stack_full) begin
               status_in = ST_OVERFLOW;
            end else begin
               op_cmd   = CMD_PUSH;
               count_in = count_ff + CntWidth'(1);
            end
         end
         OP_POP, OP_PEEK: begin
            if (stack_empty) begin
               status_in = ST_UNDERFLOW;
            end else begin
               result_in = top_ext[RESULT_WIDTH-1:0];
               if (op_type'(req_if.operation) == OP_POP) begin
                  op_cmd   = CMD_POP;
                  count_in = count_ff - CntWidth'(1);
               end
            end
         end
         OP_SEARCH: begin
            found_in = found_any;
            if (found_any) begin
               dist_in = dist_wide[DISTANCE_WIDTH-1:0];
            end
         end
         OP_REMOVE: begin
            found_in = found_any;
            if (found_any) begin
               op_cmd   = CMD_REMOVE;
               count_in = count_ff - CntWidth'(1);
            end
         end
         default: begin
            op_cmd = CMD_HOLD;
         end
      endcase
   end

   assign occ_wide = {{OCCUPANCY_WIDTH{1'b0}}, count_in};
   assign occ_in   = occ_wide[OCCUPANCY_WIDTH-1:0];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
         found_ff  <= found_in;
         dist_ff   <= dist_in;
         status_ff <= status_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.result_value      = result_ff;
   assign rsp_if.found             = found_ff;
   assign rsp_if.distance_from_top = dist_ff;
   assign rsp_if.status            = status_ff;
   assign rsp_if.occupancy         = occ_ff;

endmodule

`default_nettype wire

/* design/lss_cell.sv */
// ----------------------------------------------------------------------------
// lifo stack cell
// one stack word: compares against the key and shifts with its neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module lss_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire lss_pkg::cell_cmd_type  cmd,
   input  wire logic [VALUE_WIDTH-1:0] key,
   input  wire logic                   occupied,
   input  wire logic [VALUE_WIDTH-1:0] upper_value,
   input  wire logic [VALUE_WIDTH-1:0] lower_value,
   input  wire logic                   hit_in,
   output      logic                   hit_out,
   output      logic                   match,
   output      logic [VALUE_WIDTH-1:0] value
);
   import lss_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff, value_in;

   assign match   = occupied && (value_ff == key);
   // a match here or nearer the top
   assign hit_out = hit_in || match;
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      case (cmd)
         CMD_PUSH:   value_in = upper_value;
         CMD_POP:    value_in = lower_value;
         CMD_REMOVE: begin
            if (hit_out) begin
               value_in = lower_value;
            end
         end
         default:    value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

/* design/lss_checker.sv */
// ----------------------------------------------------------------------------
// lifo stack checker
// port-level assertions on the response channel of the lifo stack
// ----------------------------------------------------------------------------
`default_nettype none

`include "lifo_stack_with_search_remove_assert.svh"

module lss_checker #(
   parameter int DEPTH = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_result_value,
   input wire logic        rsp_found,
   input wire logic [3:0]  rsp_distance_from_top,
   input wire logic [1:0]  rsp_status,
   input wire logic [4:0]  rsp_occupancy
);
   import lss_pkg::*;

   localparam logic [OCCUPANCY_WIDTH-1:0] FullOcc = OCCUPANCY_WIDTH'(DEPTH);

   // stalled response holds
   `LSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status) && $stable(rsp_occupancy), "stalled response changed")

   // underflow only on an empty stack, with no value
   `LSS_ASSERT_IMPLY(a_underflow, clock, reset, rsp_valid && rsp_status == ST_UNDERFLOW, rsp_occupancy == '0 && rsp_result_value == '0 && !rsp_found, "bad underflow response")

   // overflow only on a full stack
   `LSS_ASSERT_IMPLY(a_overflow, clock, reset, rsp_valid && rsp_status == ST_OVERFLOW, rsp_occupancy == FullOcc && !rsp_found, "overflow below full")

   // distance is only reported with a match
   `LSS_ASSERT_IMPLY(a_distance, clock, reset, rsp_valid && !rsp_found, rsp_distance_from_top == '0, "distance without match")

endmodule

bind lifo_stack_with_search_remove lss_checker #(
   .DEPTH (DEPTH)
) u_lss_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_if.valid),
   .rsp_ready             (rsp_if.ready),
   .rsp_result_value      (rsp_if.result_value),
   .rsp_found             (rsp_if.found),
   .rsp_distance_from_top (rsp_if.distance_from_top),
   .rsp_status            (rsp_if.status),
   .rsp_occupancy         (rsp_if.occupancy)
);

`default_nettype wire
